// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/bve_pkg.sv -----
package bve_pkg;
    localparam int WORD_COUNT = 16;
    localparam int WORD_BITS  = 64;
    localparam int CAPACITY   = WORD_COUNT * WORD_BITS;
    localparam int WI_W       = $clog2(WORD_COUNT);
    localparam int LEN_W      = 11;
    localparam int POS_W      = 10;

    localparam logic [3:0] ACT_SETCLR = 4'd0;
    localparam logic [3:0] ACT_FLIP   = 4'd1;
    localparam logic [3:0] ACT_TEST   = 4'd2;
    localparam logic [3:0] ACT_SETALL = 4'd3;
    localparam logic [3:0] ACT_CLRALL = 4'd4;
    localparam logic [3:0] ACT_INVALL = 4'd5;
    localparam logic [3:0] ACT_COUNT  = 4'd6;
    localparam logic [3:0] ACT_FFIRST = 4'd7;
    localparam logic [3:0] ACT_FNEXT  = 4'd8;
    localparam logic [3:0] ACT_SHL    = 4'd9;
    localparam logic [3:0] ACT_SHR    = 4'd10;
    localparam logic [3:0] ACT_AND    = 4'd11;
    localparam logic [3:0] ACT_OR     = 4'd12;
    localparam logic [3:0] ACT_XOR    = 4'd13;
    localparam logic [3:0] ACT_RDLOW  = 4'd14;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

    typedef struct packed {
        logic       start;
        logic       walk;
        logic       last;
        logic       finish;
        logic       take;
    } cmd_t;

    typedef struct packed {
        logic       walk_needed;
    } stat_t;

    typedef struct packed {
        logic [3:0]        action;
        logic [POS_W-1:0]  bit_position;
        logic              bit_value;
        logic [LEN_W-1:0]  shift_amount;
        logic [3:0]        word_index;
        logic [63:0]       word_data;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              bit_out;
        logic              found;
        logic [POS_W-1:0]  found_position;
        logic [LEN_W-1:0]  set_count;
        logic              any_set;
        logic              all_set;
        logic [63:0]       data_out;
    } rsp_t;

    // Keep mask for word w at length len.
    function automatic logic [WORD_BITS-1:0] word_mask(input logic [WI_W-1:0] w,
                                                       input logic [LEN_W-1:0] len);
        logic [LEN_W+1:0] base;
        logic [LEN_W+1:0] rem;
        base = {{2{1'b0}}, len} - ((LEN_W+2)'(w) * (LEN_W+2)'(WORD_BITS));
        if ({{2{1'b0}}, len} <= ((LEN_W+2)'(w) * (LEN_W+2)'(WORD_BITS)))
            return '0;
        rem = base;
        if (rem >= (LEN_W+2)'(WORD_BITS))
            return '1;
        return ~({WORD_BITS{1'b1}} << rem[5:0]);
    endfunction
endpackage

// ----- rtl/core/bve_if.sv -----
interface bve_req_if;
    import bve_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bve_rsp_if;
    import bve_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/bve_ctrl.sv -----
module bve_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  bve_pkg::stat_t stat,
    output bve_pkg::cmd_t  cmd
);
    import bve_pkg::*;

    state_t             state_reg, state_next;
    logic [WI_W-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.walk_needed)
                begin
                    cmd.walk = 1'b1;
                    cmd.last = (cnt_reg == WI_W'(WORD_COUNT - 1));
                    cnt_next = cnt_reg + 1'b1;
                    if (cmd.last)
                        state_next = S_DONE;
                end
                else
                    state_next = S_DONE;
                if (state_next == S_DONE)
                    cmd.finish = 1'b1;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ----- rtl/core/bve_datapath.sv -----
module bve_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bve_pkg::req_t             req,
    input  logic                      cfg_we,
    input  logic [bve_pkg::LEN_W-1:0] cfg_data,
    input  bve_pkg::cmd_t             cmd,
    output bve_pkg::stat_t            stat,
    output bve_pkg::rsp_t             rsp
);
    import bve_pkg::*;

    logic [WORD_BITS-1:0] words_reg [WORD_COUNT];
    logic [WORD_BITS-1:0] words_next [WORD_COUNT];
    logic [WORD_BITS-1:0] src_reg [WORD_COUNT];
    req_t                 req_reg;
    rsp_t                 rsp_reg, rsp_next;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     cfg_len;
    logic [WI_W-1:0]      idx_reg;
    logic                 hit_reg, hit_next;
    logic [LEN_W-1:0]     start_pos;
    logic                 walk_op;

    // Everything but count, find and a shift by a nonzero amount below a nonzero length is settled in one step.
    always_comb
    begin
        case (req_reg.action)
            ACT_COUNT, ACT_FFIRST, ACT_FNEXT: walk_op = 1'b1;
            ACT_SHL, ACT_SHR:
                walk_op = (req_reg.shift_amount != '0) && (len_reg != '0)
                          && (req_reg.shift_amount < len_reg);
            default: walk_op = 1'b0;
        endcase
    end
    assign stat.walk_needed = walk_op;
    assign rsp = rsp_reg;
    assign cfg_len = (cfg_data > LEN_W'(CAPACITY)) ? LEN_W'(CAPACITY) : cfg_data;
    assign start_pos = (req_reg.action == ACT_FNEXT) ? LEN_W'(req_reg.bit_position) + 1'b1
                                                    : '0;

    always_comb
    begin
        logic [WORD_BITS-1:0] w, x, lo, hi, m;
        logic [WI_W:0]        sw;
        logic [5:0]           os;
        logic [WI_W-1:0]      bs;
        logic [WI_W-1:0]      pw;
        logic [5:0]           pb;
        logic [LEN_W-1:0]     pc;
        int                   k;
        for (int i = 0; i < WORD_COUNT; i++)
            words_next[i] = words_reg[i];
        rsp_next = rsp_reg;
        hit_next = hit_reg;
        pw = req_reg.bit_position[POS_W-1:6];
        pb = req_reg.bit_position[5:0];
        os = req_reg.shift_amount[5:0];
        bs = req_reg.shift_amount[LEN_W-2:6];
        w  = words_reg[idx_reg];
        lo = '0;
        hi = '0;
        pc = '0;
        k  = 0;
        if (cmd.start)
        begin
            rsp_next = '0;
            hit_next = 1'b0;
        end
        else if (cmd.walk)
        begin
            case (req_reg.action)
                ACT_COUNT:
                begin
                    for (k = 0; k < WORD_BITS; k++)
                        pc = pc + LEN_W'(w[k]);
                    rsp_next.set_count = rsp_reg.set_count + pc;
                end
                ACT_FFIRST, ACT_FNEXT:
                begin
                    x = w;
                    if ({1'b0, idx_reg} < start_pos[LEN_W-1:6] || start_pos[LEN_W-1])
                        x = '0;
                    else if (idx_reg == start_pos[LEN_W-2:6])
                        x = w & ({WORD_BITS{1'b1}} << start_pos[5:0]);
                    if (start_pos >= len_reg)
                        x = '0;
                    if (!hit_reg && x != '0)
                    begin
                        hit_next = 1'b1;
                        rsp_next.found = 1'b1;
                        for (k = WORD_BITS - 1; k >= 0; k--)
                            if (x[k])
                                rsp_next.found_position = {idx_reg, 6'(k)};
                    end
                end
                default:
                begin
                    // Shift: build one destination word from the snapshot.
                    if (req_reg.action == ACT_SHL)
                    begin
                        sw = {1'b0, idx_reg} - (WI_W+1)'(bs);
                        if (!sw[WI_W])
                        begin
                            lo = src_reg[sw[WI_W-1:0]] << os;
                            if (os != '0 && sw[WI_W-1:0] != '0)
                                hi = src_reg[sw[WI_W-1:0] - 1'b1] >> (7'd64 - 7'(os));
                        end
                    end
                    else
                    begin
                        sw = {1'b0, idx_reg} + (WI_W+1)'(bs);
                        if (!sw[WI_W])
                        begin
                            lo = src_reg[sw[WI_W-1:0]] >> os;
                            if (os != '0 && sw[WI_W-1:0] != WI_W'(WORD_COUNT-1))
                                hi = src_reg[sw[WI_W-1:0] + 1'b1] << (7'd64 - 7'(os));
                        end
                    end
                    words_next[idx_reg] = (lo | hi) & word_mask(idx_reg, len_reg);
                end
            endcase
            if (cmd.last && req_reg.action == ACT_COUNT)
            begin
                rsp_next.any_set = (rsp_next.set_count != '0);
                rsp_next.all_set = (rsp_next.set_count == len_reg);
            end
        end
        else if (cmd.finish)
        begin
            m = WORD_BITS'(1) << pb;
            case (req_reg.action)
                ACT_SETCLR, ACT_FLIP, ACT_TEST:
                begin
                    if (LEN_W'(req_reg.bit_position) >= len_reg)
                        rsp_next.status = ST_RANGE;
                    else if (req_reg.action == ACT_SETCLR)
                        words_next[pw] = req_reg.bit_value ? (words_reg[pw] | m)
                                                           : (words_reg[pw] & ~m);
                    else if (req_reg.action == ACT_FLIP)
                        words_next[pw] = words_reg[pw] ^ m;
                    else
                        rsp_next.bit_out = |(words_reg[pw] & m);
                end
                ACT_SETALL:
                    for (int i = 0; i < WORD_COUNT; i++)
                        words_next[i] = word_mask(WI_W'(i), len_reg);
                ACT_CLRALL:
                    for (int i = 0; i < WORD_COUNT; i++)
                        words_next[i] = '0;
                ACT_INVALL:
                    for (int i = 0; i < WORD_COUNT; i++)
                        words_next[i] = ~words_reg[i] & word_mask(WI_W'(i), len_reg);
                ACT_SHL, ACT_SHR:
                    if (req_reg.shift_amount >= len_reg && req_reg.shift_amount != '0
                        && len_reg != '0)
                        for (int i = 0; i < WORD_COUNT; i++)
                            words_next[i] = '0;
                ACT_AND:
                    words_next[req_reg.word_index] = words_reg[req_reg.word_index]
                        & req_reg.word_data & word_mask(req_reg.word_index, len_reg);
                ACT_OR:
                    words_next[req_reg.word_index] = (words_reg[req_reg.word_index]
                        | req_reg.word_data) & word_mask(req_reg.word_index, len_reg);
                ACT_XOR:
                    words_next[req_reg.word_index] = (words_reg[req_reg.word_index]
                        ^ req_reg.word_data) & word_mask(req_reg.word_index, len_reg);
                ACT_RDLOW:
                begin
                    rsp_next.data_out = words_reg[0];
                    for (int i = 1; i < WORD_COUNT; i++)
                        if (words_reg[i] != '0)
                            rsp_next.status = ST_OVF;
                end
                default: ;
            endcase
        end
        if (cfg_we)
            for (int i = 0; i < WORD_COUNT; i++)
                words_next[i] = words_reg[i] & word_mask(WI_W'(i), cfg_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
                words_reg[i] <= '0;
            len_reg <= LEN_W'(CAPACITY);
            idx_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < WORD_COUNT; i++)
                words_reg[i] <= words_next[i];
            if (cfg_we)
                len_reg <= cfg_len;
            hit_reg <= hit_next;
            if (cmd.start)
                idx_reg <= '0;
            else if (cmd.walk)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd.start)
            req_reg <= req;
        if (cmd.start)
            for (int i = 0; i < WORD_COUNT; i++)
                src_reg[i] <= words_reg[i];
    end
endmodule

// ----- rtl/core/bit_vector_engine.sv -----
// Bit vector engine: holds a vector of up to 1024 bits in sixteen 64-bit
// words and performs one operation per request beat, giving one response
// beat for each. Single-bit, whole-vector, word and read-low operations, and
// shifts by zero, at zero length or by at least the length, finish in
// S_WALK without a walk and offer their result beat in S_DONE; count, find
// and other shift operations walk every stored word through one shared
// word unit, one word per cycle, before the result beat is offered in
// S_DONE. A new request is taken once the previous result beat has gone, so
// a stalled result holds off the input for as long as it waits. The length
// register is written through cfg_we/cfg_data and clips stored bits above
// the new length at once.
module bit_vector_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    bve_req_if.sink                   req,
    bve_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [bve_pkg::LEN_W-1:0] cfg_data
);
    import bve_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bve_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bve_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req.data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .rsp      (rsp.data)
    );
endmodule

// ----- rtl/core/bve_checker.sv -----
`include "assert_macros.svh"
module bve_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         req_valid,
    input logic         req_ready,
    input logic         rsp_valid,
    input logic         rsp_ready,
    input bve_pkg::rsp_t rsp_data
);
    import bve_pkg::*;
    `ASSERT_IMPL(a_excl, clk, rst_n, rsp_valid, !req_ready)
    `ASSERT_NEXT(a_acc_busy, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASSERT_NEXT(a_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
    `ASSERT_IMPL(a_cnt, clk, rst_n, rsp_valid, rsp_data.set_count <= LEN_W'(CAPACITY))
endmodule

bind bit_vector_engine bve_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
